// ===== rtl/converter_power_sequencer_defines.svh =====
// assertion macros for the power sequencer
`ifndef CONVERTER_POWER_SEQUENCER_DEFINES_SVH
`define CONVERTER_POWER_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("power sequencer check failed");

// next-cycle implication, checked out of reset
`define CPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("power sequencer check failed");

`endif

// ===== rtl/cps_pkg.sv =====
// types, codes and helpers shared by the power sequencer modules
package cps_pkg;

  localparam int unsigned AdcW    = 10;
  localparam int unsigned TickW   = 16;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned PeriodW = 15;
  localparam int unsigned RampShift = 8;
  localparam int unsigned StepW   = PeriodW - RampShift;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DutyW-1:0] NullDuty = DutyW'(10);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_READY = 3'd1,
    MODE_START = 3'd2,
    MODE_RUN   = 3'd3,
    MODE_STOP  = 3'd4,
    MODE_FAULT = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    FLT_NONE      = 2'd0,
    FLT_PRECHARGE = 2'd1,
    FLT_DIRECT    = 2'd2,
    FLT_DISCHARGE = 2'd3
  } fault_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUS_LOW      = 3'd0,
    CFG_BUS_HIGH     = 3'd1,
    CFG_DISCH_LEVEL  = 3'd2,
    CFG_PRECH_TICKS  = 3'd3,
    CFG_DISCH_TICKS  = 3'd4,
    CFG_PWM_PERIOD   = 3'd5,
    CFG_DUTY_TARGET  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [AdcW-1:0]    bus_low;
    logic [AdcW-1:0]    bus_high;
    logic [AdcW-1:0]    disch_level;
    logic [TickW-1:0]   prech_ticks;
    logic [TickW-1:0]   disch_ticks;
    logic [PeriodW-1:0] pwm_period;
    logic [DutyW-1:0]   duty_target;
  } cfg_t;

  typedef struct packed {
    logic running;
    logic discharge;
    logic direct;
    logic precharge;
    logic breaker;
  } drv_t;

  function automatic logic [15:0] sat_add16(logic [15:0] a, logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

endpackage

// ===== rtl/cps_cfg_regs.sv =====
// configuration register file of the power sequencer
module cps_cfg_regs import cps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CFG_BUS_LOW:     cfg_d.bus_low     = wr_data_i[AdcW-1:0];
        CFG_BUS_HIGH:    cfg_d.bus_high    = wr_data_i[AdcW-1:0];
        CFG_DISCH_LEVEL: cfg_d.disch_level = wr_data_i[AdcW-1:0];
        CFG_PRECH_TICKS: cfg_d.prech_ticks = wr_data_i[TickW-1:0];
        CFG_DISCH_TICKS: cfg_d.disch_ticks = wr_data_i[TickW-1:0];
        CFG_PWM_PERIOD:  cfg_d.pwm_period  = wr_data_i[PeriodW-1:0];
        CFG_DUTY_TARGET: cfg_d.duty_target = wr_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bus_low     <= '0;
      cfg_q.bus_high    <= '1;
      cfg_q.disch_level <= '0;
      cfg_q.prech_ticks <= '0;
      cfg_q.disch_ticks <= '0;
      cfg_q.pwm_period  <= '0;
      cfg_q.duty_target <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/cps_core.sv =====
// sequencer state and the per-word update logic
module cps_core import cps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cfg_t              cfg_i,
  input  logic [AdcW-1:0]   bus_i,
  input  logic [AdcW-1:0]   cap_i,
  input  logic              req_i,
  input  logic [TickW-1:0]  dt_i,
  output mode_e             mode_o,
  output logic [DutyW-1:0]  duty_o,
  output drv_t              drv_o,
  output fault_e            fault_o
);

  mode_e            mode_q, mode_d;
  logic [DutyW-1:0] duty_q, duty_d;
  logic             ramp_q, ramp_d;
  logic             stop_q, stop_d;
  logic [TickW-1:0] pacc_q, pacc_d;
  logic [TickW-1:0] dacc_q, dacc_d;
  drv_t             drv_q, drv_d;
  fault_e           fault_q, fault_d;

  logic             bus_ok, cap_in_win, cap_low;
  logic [DutyW-1:0] step;
  logic [TickW-1:0] pacc_sum, dacc_sum;
  logic             prech_done, disch_done;
  logic             at_target;
  logic [DutyW-1:0] duty_up, duty_dn_raw, duty_dn;
  logic             below_null, stop_eff;
  logic             prech_check, ramp_eff, disch_end;

  // shared conditions
  assign bus_ok      = (bus_i >= cfg_i.bus_low) && (bus_i <= cfg_i.bus_high);
  assign cap_in_win  = (cap_i > cfg_i.bus_low) && (cap_i < cfg_i.bus_high);
  assign cap_low     = cap_i < cfg_i.disch_level;
  assign step        = DutyW'(cfg_i.pwm_period[PeriodW-1:RampShift]);
  assign pacc_sum    = sat_add16(pacc_q, dt_i);
  assign dacc_sum    = sat_add16(dacc_q, dt_i);
  assign prech_done  = pacc_sum > cfg_i.prech_ticks;
  assign disch_done  = dacc_sum > cfg_i.disch_ticks;
  assign at_target   = duty_q >= cfg_i.duty_target;
  assign duty_up     = sat_add16(duty_q, step);
  assign duty_dn_raw = (duty_q > step) ? (duty_q - step) : '0;
  assign below_null  = duty_dn_raw < NullDuty;
  assign duty_dn     = below_null ? '0 : duty_dn_raw;
  assign stop_eff    = stop_q || below_null;
  assign prech_check = !ramp_q && prech_done;
  assign ramp_eff    = ramp_q || (prech_done && bus_ok && cap_in_win);
  assign disch_end   = stop_eff && disch_done;

  // next mode
  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      MODE_IDLE: begin
        if (bus_ok) mode_d = MODE_READY;
      end
      MODE_READY: begin
        if (!bus_ok)    mode_d = MODE_IDLE;
        else if (req_i) mode_d = MODE_START;
      end
      MODE_START: begin
        if (prech_check && !(bus_ok && cap_in_win)) mode_d = MODE_FAULT;
        else if (ramp_eff && at_target)             mode_d = MODE_RUN;
      end
      MODE_RUN: begin
        if (!req_i) mode_d = MODE_STOP;
      end
      MODE_STOP: begin
        if (disch_end) mode_d = cap_low ? MODE_IDLE : MODE_FAULT;
      end
      default: ;
    endcase
  end

  // datapath and drive latches
  always_comb begin
    duty_d  = duty_q;
    ramp_d  = ramp_q;
    stop_d  = stop_q;
    pacc_d  = pacc_q;
    dacc_d  = dacc_q;
    drv_d   = drv_q;
    fault_d = fault_q;
    case (mode_q)
      MODE_IDLE: begin
        drv_d.breaker = 1'b1;
      end
      MODE_READY: begin
        if (!bus_ok) begin
          ramp_d  = 1'b0;
          stop_d  = 1'b0;
          pacc_d  = '0;
          dacc_d  = '0;
          fault_d = FLT_NONE;
          drv_d   = '{breaker: drv_q.breaker, default: 1'b0};
        end
      end
      MODE_START: begin
        if (!ramp_q) begin
          drv_d.precharge = 1'b1;
          pacc_d = pacc_sum;
          if (prech_done) begin
            if (!bus_ok) begin
              fault_d = FLT_PRECHARGE;
            end else begin
              drv_d.direct = 1'b1;
              if (cap_in_win) begin
                drv_d.breaker = 1'b1;
                ramp_d = 1'b1;
              end else begin
                fault_d = FLT_DIRECT;
              end
            end
          end
        end
        if (ramp_eff && !at_target) duty_d = duty_up;
      end
      MODE_RUN: begin
        drv_d.running = 1'b1;
      end
      MODE_STOP: begin
        duty_d = duty_dn;
        if (below_null && !stop_q) begin
          drv_d.direct    = 1'b0;
          drv_d.discharge = 1'b1;
          stop_d = 1'b1;
        end
        if (stop_eff) dacc_d = dacc_sum;
        if (disch_end) begin
          if (cap_low) begin
            ramp_d  = 1'b0;
            stop_d  = 1'b0;
            pacc_d  = '0;
            dacc_d  = '0;
            fault_d = FLT_NONE;
            drv_d   = '{breaker: drv_q.breaker, default: 1'b0};
          end else begin
            fault_d = FLT_DISCHARGE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      duty_q  <= '0;
      ramp_q  <= 1'b0;
      stop_q  <= 1'b0;
      pacc_q  <= '0;
      dacc_q  <= '0;
      drv_q   <= '0;
      fault_q <= FLT_NONE;
    end else if (step_i) begin
      mode_q  <= mode_d;
      duty_q  <= duty_d;
      ramp_q  <= ramp_d;
      stop_q  <= stop_d;
      pacc_q  <= pacc_d;
      dacc_q  <= dacc_d;
      drv_q   <= drv_d;
      fault_q <= fault_d;
    end
  end

  assign mode_o  = mode_q;
  assign duty_o  = duty_q;
  assign drv_o   = drv_q;
  assign fault_o = fault_q;

endmodule

// ===== rtl/converter_power_sequencer.sv =====
// top level of the converter power sequencer
//
//  channel | direction | handshake             | payload
//  input   | in        | in_valid_i/in_stall_o | bus, cap, start request, elapsed ticks
//  output  | out       | out_valid_o/out_stall_i | mode, duty, drives, fault code
//  config  | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word per cycle unless the receiver stalls the result
// the input register feeds the state update, the state registers are the result
// async active-low reset: idle mode, drives off, limits at reset values
// a stalled result holds the next word in the input register
`include "converter_power_sequencer_defines.svh"

module converter_power_sequencer import cps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [AdcW-1:0]     bus_voltage_i,
  input  logic [AdcW-1:0]     cap_voltage_i,
  input  logic                start_request_i,
  input  logic [TickW-1:0]    elapsed_ticks_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          mode_code_o,
  output logic [DutyW-1:0]    duty_value_o,
  output logic                breaker_closed_o,
  output logic                precharge_on_o,
  output logic                direct_contact_on_o,
  output logic                discharge_gate_on_o,
  output logic                running_flag_o,
  output logic [1:0]          fault_code_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t             cfg;
  mode_e            mode;
  drv_t             drv;
  fault_e           fault;
  logic [DutyW-1:0] duty;

  logic             s1_valid_q, s1_valid_d;
  logic [AdcW-1:0]  bus_q, cap_q;
  logic             req_q;
  logic [TickW-1:0] dt_q;
  logic             out_valid_q, out_valid_d;
  logic             accept, s1_fire;

  assign cfg_ready_o = 1'b1;

  cps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign s1_fire    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input word register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bus_q <= bus_voltage_i;
      cap_q <= cap_voltage_i;
      req_q <= start_request_i;
      dt_q  <= elapsed_ticks_i;
    end
  end

  cps_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_fire),
    .cfg_i   (cfg),
    .bus_i   (bus_q),
    .cap_i   (cap_q),
    .req_i   (req_q),
    .dt_i    (dt_q),
    .mode_o  (mode),
    .duty_o  (duty),
    .drv_o   (drv),
    .fault_o (fault)
  );

  assign out_valid_o         = out_valid_q;
  assign mode_code_o         = mode;
  assign duty_value_o        = duty;
  assign breaker_closed_o    = drv.breaker;
  assign precharge_on_o      = drv.precharge;
  assign direct_contact_on_o = drv.direct;
  assign discharge_gate_on_o = drv.discharge;
  assign running_flag_o      = drv.running;
  assign fault_code_o        = fault;

  `CPS_ASSERT_IMPL(a_fault_only_in_fault, fault_code_o != FLT_NONE, mode_code_o == MODE_FAULT)
  `CPS_ASSERT_IMPL(a_running_late_modes, running_flag_o,
                   mode_code_o == MODE_RUN || mode_code_o == MODE_STOP ||
                   mode_code_o == MODE_FAULT)
  `CPS_ASSERT_NEXT(a_state_holds_idle, !s1_fire,
                   $stable(mode_code_o) && $stable(duty_value_o))
  `CPS_ASSERT_IMPL(a_stall_needs_result, in_stall_o, out_valid_o && s1_valid_q)

endmodule

// ===== test/converter_power_sequencer_tb.sv =====
// self-checking converter power sequencer testbench, directed and random stimulus vs a predictor
`timescale 1ns / 1ps

module converter_power_sequencer_tb import cps_pkg::*; ();

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 100;
  localparam int unsigned ReportCap  = 40;

  typedef struct packed {
    logic [AdcW-1:0]  bus;
    logic [AdcW-1:0]  cap;
    logic             req;
    logic [TickW-1:0] ticks;
  } reading_t;

  typedef struct packed {
    mode_e             mode;
    logic [DutyW-1:0]  duty;
    logic              ramp;
    logic              stop_lat;
    logic [TickW-1:0]  pre_acc;
    logic [TickW-1:0]  dis_acc;
    drv_t              drv;
    fault_e            fault;
  } seq_state_t;

  typedef struct packed {
    logic [AdcW-1:0]    low;
    logic [AdcW-1:0]    high;
    logic [AdcW-1:0]    disch_level;
    logic [TickW-1:0]   prech_ticks;
    logic [TickW-1:0]   disch_ticks;
    logic [PeriodW-1:0] period;
    logic [DutyW-1:0]   duty_target;
  } limits_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [AdcW-1:0]     bus_voltage_i;
  logic [AdcW-1:0]     cap_voltage_i;
  logic                start_request_i;
  logic [TickW-1:0]    elapsed_ticks_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          mode_code_o;
  logic [DutyW-1:0]    duty_value_o;
  logic                breaker_closed_o;
  logic                precharge_on_o;
  logic                direct_contact_on_o;
  logic                discharge_gate_on_o;
  logic                running_flag_o;
  logic [1:0]          fault_code_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  limits_t     limits = '{low: '0, high: 10'd1023, disch_level: '0, prech_ticks: '0,
                          disch_ticks: '0, period: '0, duty_target: '0};
  seq_state_t  tracked = '0;
  seq_state_t  pending_status[$];
  fault_e      fault_aim = FLT_NONE;
  logic [5:0]  modes_seen = '0;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned settings_loaded = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_pct = 25;
  int unsigned stall_pct = 27;
  int unsigned hold_left = 0;
  bit          hold_pending = 1'b0;

  converter_power_sequencer i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .bus_voltage_i       (bus_voltage_i),
    .cap_voltage_i       (cap_voltage_i),
    .start_request_i     (start_request_i),
    .elapsed_ticks_i     (elapsed_ticks_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .mode_code_o         (mode_code_o),
    .duty_value_o        (duty_value_o),
    .breaker_closed_o    (breaker_closed_o),
    .precharge_on_o      (precharge_on_o),
    .direct_contact_on_o (direct_contact_on_o),
    .discharge_gate_on_o (discharge_gate_on_o),
    .running_flag_o      (running_flag_o),
    .fault_code_o        (fault_code_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] add_sat(logic [15:0] a, logic [15:0] b);
    logic [16:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[16] ? 16'hFFFF : total[15:0];
  endfunction

  function automatic seq_state_t back_to_idle(seq_state_t s);
    s.mode          = MODE_IDLE;
    s.ramp          = 1'b0;
    s.stop_lat      = 1'b0;
    s.pre_acc       = '0;
    s.dis_acc       = '0;
    s.fault         = FLT_NONE;
    s.drv.precharge = 1'b0;
    s.drv.direct    = 1'b0;
    s.drv.discharge = 1'b0;
    s.drv.running   = 1'b0;
    return s;
  endfunction

  function automatic seq_state_t sequencer_next(seq_state_t s, reading_t r);
    logic [DutyW-1:0] step;
    logic             bus_ok;
    step   = DutyW'(limits.period >> RampShift);
    bus_ok = (r.bus >= limits.low) && (r.bus <= limits.high);
    case (s.mode)
      MODE_IDLE: begin
        s.drv.breaker = 1'b1;
        if (bus_ok) s.mode = MODE_READY;
      end
      MODE_READY: begin
        if (!bus_ok) s = back_to_idle(s);
        else if (r.req) s.mode = MODE_START;
      end
      MODE_START: begin
        if (!s.ramp) begin
          s.drv.precharge = 1'b1;
          s.pre_acc = add_sat(s.pre_acc, r.ticks);
          if (s.pre_acc > limits.prech_ticks) begin
            if (bus_ok) begin
              s.drv.direct = 1'b1;
              if (r.cap > limits.low && r.cap < limits.high) begin
                s.drv.breaker = 1'b1;
                s.ramp = 1'b1;
              end else begin
                s.fault = FLT_DIRECT;
                s.mode  = MODE_FAULT;
              end
            end else begin
              s.fault = FLT_PRECHARGE;
              s.mode  = MODE_FAULT;
            end
          end
        end
        if (s.ramp) begin
          if (s.duty >= limits.duty_target) s.mode = MODE_RUN;
          else s.duty = add_sat(s.duty, step);
        end
      end
      MODE_RUN: begin
        s.drv.running = 1'b1;
        if (!r.req) s.mode = MODE_STOP;
      end
      MODE_STOP: begin
        if (s.duty != '0) s.duty = (s.duty > step) ? s.duty - step : '0;
        if (s.duty < NullDuty) begin
          s.duty = '0;
          if (!s.stop_lat) begin
            s.drv.direct    = 1'b0;
            s.drv.discharge = 1'b1;
            s.stop_lat      = 1'b1;
          end
        end
        if (s.stop_lat) begin
          s.dis_acc = add_sat(s.dis_acc, r.ticks);
          if (s.dis_acc > limits.disch_ticks) begin
            if (r.cap < limits.disch_level) begin
              s = back_to_idle(s);
            end else begin
              s.fault = FLT_DISCHARGE;
              s.mode  = MODE_FAULT;
            end
          end
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  // steers toward well-formed sequences, with plain noise mixed in
  function automatic reading_t steer_reading();
    reading_t r;
    int       lo;
    int       hi;
    int       lvl;
    int       span;
    lo      = limits.low;
    hi      = limits.high;
    lvl     = limits.disch_level;
    r.bus   = AdcW'($urandom);
    r.cap   = AdcW'($urandom);
    r.req   = 1'($urandom);
    r.ticks = TickW'($urandom);
    if ($urandom_range(99) < 20) return r;
    span = (tracked.mode == MODE_STOP) ? limits.disch_ticks : limits.prech_ticks;
    if ($urandom_range(99) < 75) r.ticks = TickW'($urandom_range(0, span / 2 + 2));
    if (lo <= hi && $urandom_range(99) < 90) r.bus = AdcW'($urandom_range(lo, hi));
    case (tracked.mode)
      MODE_READY: r.req = ($urandom_range(99) < 60);
      MODE_RUN:   r.req = ($urandom_range(99) < 85);
      MODE_START: begin
        if (hi - lo >= 2) r.cap = AdcW'($urandom_range(lo + 1, hi - 1));
        if (fault_aim == FLT_PRECHARGE && $urandom_range(1) && lo > 0 && hi < 1023) begin
          r.bus = $urandom_range(1) ? AdcW'($urandom_range(0, lo - 1))
                                    : AdcW'($urandom_range(hi + 1, 1023));
        end
        if (fault_aim == FLT_DIRECT && $urandom_range(1)) begin
          r.cap = $urandom_range(1) ? AdcW'(lo) : AdcW'(hi);
        end
      end
      MODE_STOP: begin
        if (lvl > 0) r.cap = AdcW'($urandom_range(0, lvl - 1));
        if (fault_aim == FLT_DISCHARGE && $urandom_range(1)) begin
          r.cap = AdcW'($urandom_range(lvl, 1023));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // fault mode is terminal, so it is kept out until the last test
  function automatic reading_t pick_reading();
    reading_t   r;
    seq_state_t nxt;
    int         lo;
    int         hi;
    lo = limits.low;
    hi = limits.high;
    for (int i = 0; i < 8; i++) begin
      r   = steer_reading();
      nxt = sequencer_next(tracked, r);
      if (fault_aim != FLT_NONE || nxt.mode != MODE_FAULT) return r;
    end
    r.ticks = '0;
    if (tracked.mode == MODE_STOP) begin
      r.cap = '0;
    end else if (hi - lo >= 2) begin
      r.bus = AdcW'(lo);
      r.cap = AdcW'(lo + 1);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < ReportCap) begin
      $display("mismatch on %s: got %0d, expected %0d (word %0d, %0t)",
               what, got, want, words_checked, $realtime);
    end
    mismatches++;
  endtask

  task automatic send_reading(input reading_t r);
    bit taken;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    bus_voltage_i   <= r.bus;
    cap_voltage_i   <= r.cap;
    start_request_i <= r.req;
    elapsed_ticks_i <= r.ticks;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) begin
        tracked = sequencer_next(tracked, r);
        pending_status.push_back(tracked);
        modes_seen[tracked.mode] = 1'b1;
      end
      @(posedge clk_i);
    end
  endtask

  task automatic run_readings(input int unsigned count);
    repeat (count) send_reading(pick_reading());
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    logic [CfgDataW-1:0] word;
    bit                  taken;
    word = value;
    case (idx)
      CFG_BUS_LOW, CFG_BUS_HIGH, CFG_DISCH_LEVEL: word[15:10] = 6'($urandom);
      CFG_PWM_PERIOD: word[15] = 1'($urandom);
      default: ;
    endcase
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      if (taken) begin
        case (idx)
          CFG_BUS_LOW:     limits.low         = word[AdcW-1:0];
          CFG_BUS_HIGH:    limits.high        = word[AdcW-1:0];
          CFG_DISCH_LEVEL: limits.disch_level = word[AdcW-1:0];
          CFG_PRECH_TICKS: limits.prech_ticks = word;
          CFG_DISCH_TICKS: limits.disch_ticks = word;
          CFG_PWM_PERIOD:  limits.period      = word[PeriodW-1:0];
          CFG_DUTY_TARGET: limits.duty_target = word;
          default: ;
        endcase
      end
      @(posedge clk_i);
    end
  endtask

  task automatic load_settings(input int low, input int high, input int level,
                               input int prech, input int disch, input int period,
                               input int target);
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_register(CFG_BUS_LOW, CfgDataW'(low));
    write_register(CFG_BUS_HIGH, CfgDataW'(high));
    write_register(CFG_DISCH_LEVEL, CfgDataW'(level));
    write_register(CFG_PRECH_TICKS, CfgDataW'(prech));
    write_register(CFG_DISCH_TICKS, CfgDataW'(disch));
    write_register(CFG_PWM_PERIOD, CfgDataW'(period));
    write_register(CFG_DUTY_TARGET, CfgDataW'(target));
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  // one full power-up and power-down with window edges and the small-duty cutoff
  task automatic test_directed_walk();
    load_settings(100, 900, 50, 1000, 500, 1024, 12);
    send_reading('{10'd1023, 10'd0, 1'b0, 16'd0});
    send_reading('{10'd0, 10'd1023, 1'b1, 16'hFFFF});
    send_reading('{10'd100, 10'd0, 1'b0, 16'd0});
    send_reading('{10'd901, 10'd0, 1'b1, 16'd0});
    send_reading('{10'd900, 10'd500, 1'b0, 16'd0});
    send_reading('{10'd500, 10'd500, 1'b0, 16'd7});
    send_reading('{10'd500, 10'd500, 1'b1, 16'd0});
    send_reading('{10'd0, 10'd1023, 1'b0, 16'd1000});
    send_reading('{10'd500, 10'd101, 1'b1, 16'hFFFF});
    send_reading('{10'd1023, 10'd0, 1'b0, 16'd0});
    send_reading('{10'd0, 10'd1023, 1'b0, 16'hFFFF});
    send_reading('{10'd500, 10'd500, 1'b1, 16'd0});
    send_reading('{10'd500, 10'd500, 1'b1, 16'd0});
    send_reading('{10'd500, 10'd500, 1'b0, 16'd0});
    send_reading('{10'd500, 10'd1023, 1'b0, 16'd500});
    send_reading('{10'd500, 10'd49, 1'b1, 16'd1});
  endtask

  task automatic test_backpressure();
    load_settings(200, 800, 300, 3000, 2000, 2560, 300);
    hold_pending = 1'b1;
    run_readings(250);
  endtask

  task automatic test_setting_sweep();
    load_settings(0, 1023, 1023, 65534, 65534, 32767, 65535);
    run_readings(600);
    load_settings(512, 514, 1, 0, 0, 255, 0);
    run_readings(200);
    load_settings(1023, 0, 0, 65535, 65535, 0, 0);
    run_readings(60);
    load_settings(5, 1000, 600, 10, 10, 5000, 1000);
    run_readings(240);
  endtask

  task automatic test_streaming();
    gap_pct   = 0;
    stall_pct = 0;
    load_settings(20, 1000, 900, 40, 40, 300, 20);
    run_readings(300);
    gap_pct   = 25;
    stall_pct = 27;
  endtask

  task automatic test_fault_lockout();
    int unsigned tries;
    load_settings(150, 850, 400, 300, 300, 1536, 60);
    case ($urandom_range(2))
      0:       fault_aim = FLT_PRECHARGE;
      1:       fault_aim = FLT_DIRECT;
      default: fault_aim = FLT_DISCHARGE;
    endcase
    tries = 0;
    while (tracked.mode != MODE_FAULT && tries < 400) begin
      send_reading(pick_reading());
      tries++;
    end
    run_readings(6);
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_pending && hold_left == 0) begin
      hold_pending = 1'b0;
      hold_left    = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(negedge clk_i) begin : check_word
    seq_state_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        report_mismatch("word with nothing expected", mode_code_o, 0);
      end else begin
        want = pending_status.pop_front();
        if (mode_code_o !== want.mode)
          report_mismatch("mode_code", mode_code_o, want.mode);
        if (duty_value_o !== want.duty)
          report_mismatch("duty_value", duty_value_o, want.duty);
        if (breaker_closed_o !== want.drv.breaker)
          report_mismatch("breaker_closed", breaker_closed_o, want.drv.breaker);
        if (precharge_on_o !== want.drv.precharge)
          report_mismatch("precharge_on", precharge_on_o, want.drv.precharge);
        if (direct_contact_on_o !== want.drv.direct)
          report_mismatch("direct_contact_on", direct_contact_on_o, want.drv.direct);
        if (discharge_gate_on_o !== want.drv.discharge)
          report_mismatch("discharge_gate_on", discharge_gate_on_o, want.drv.discharge);
        if (running_flag_o !== want.drv.running)
          report_mismatch("running_flag", running_flag_o, want.drv.running);
        if (fault_code_o !== want.fault)
          report_mismatch("fault_code", fault_code_o, want.fault);
        words_checked++;
      end
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == StallLimit) begin
      $display("timeout: no handshake for %0d cycles", StallLimit);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    bus_voltage_i   <= '0;
    cap_voltage_i   <= '0;
    start_request_i <= 1'b0;
    elapsed_ticks_i <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_walk();
    test_backpressure();
    test_setting_sweep();
    test_streaming();
    test_fault_lockout();

    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("summary: %0d words checked under %0d register settings, modes reached %b",
             words_checked, settings_loaded, modes_seen);
    $display("summary: final mode %0d with fault code %0d, %0d mismatches",
             tracked.mode, tracked.fault, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cps_pkg.sv
rtl/cps_cfg_regs.sv
rtl/cps_core.sv
rtl/converter_power_sequencer.sv
test/converter_power_sequencer_tb.sv
